>>> rtl/core/aac_pkg.sv
// Shared types and constants for the ADC averaging calibrator.
// No dependencies; imported by adc_averaging_calibrator.
`default_nettype none

package aac_pkg;

  // Field widths fixed by the stream format
  localparam int unsigned ACT_W = 2;
  localparam int unsigned RD_W  = 10;
  localparam int unsigned FS_W  = 16;
  localparam int unsigned MV_W  = 16;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 16;

  // Action codes carried in s_axis_tuser
  localparam logic [ACT_W-1:0] ACT_START   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SAMPLE  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CONVERT = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAVED_CAL = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 8'd1;

  // Reset value of full_scale_millivolts
  localparam logic [FS_W-1:0] FS_RESET = 16'd10000;
  localparam logic [MV_W-1:0] MV_MAX   = 16'hFFFF;

endpackage : aac_pkg

`default_nettype wire

>>> rtl/core/adc_averaging_calibrator.sv
// ADC averaging calibrator: calibration averaging and millivolt conversion.
// Depends on aac_pkg for widths, action codes and register indexes.
`default_nettype none

// Takes one beat at a time and answers each with exactly one result beat. A start beat,
// an ignored sample, or a convert with a zero calibration value goes straight to S_DONE,
// and its result is loaded into the output register once that register is free. The
// sample that completes a calibration runs the shared restoring divider in S_DIV
// (sum / SAMPLE_COUNT), then S_FIN and S_DONE; a convert passes S_MUL (the 16x10
// multiplier), then the same divider, S_FIN and S_DONE.
// The divider retires one quotient bit per cycle; s_axis_tready
// is low while an item is in the sequencer. The result sits in an output register, so
// the next beat is accepted while it waits. Configuration writes are always accepted
// and must be issued while the block is idle; writing saved_calibration reloads the
// calibration value at once.
module adc_averaging_calibrator
  import aac_pkg::*;
#(
  parameter int unsigned SAMPLE_COUNT = 100,
  parameter int unsigned ADC_BITS     = 10
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration write channel
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_data_i,
  // input stream
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [15:0]          s_axis_tdata,   // [9:0] reading, [15:10] zero
  input  wire logic [ACT_W-1:0]     s_axis_tuser,   // [1:0] action
  // result stream
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [31:0]               m_axis_tdata    // [15:0] millivolts, [16] saturated,
                                                    // [17] divide_error, [18] in_progress,
                                                    // [19] store_strobe,
                                                    // [29:20] current_calibration,
                                                    // [31:30] zero
);

  // Derived widths
  localparam int unsigned CNT_W  = $clog2(SAMPLE_COUNT + 1);
  localparam int unsigned SUM_W  = RD_W + CNT_W;
  localparam int unsigned DV_W   = RD_W;
  localparam int unsigned DIVD_W = FS_W + RD_W;
  localparam int unsigned ITER_W = $clog2(DIVD_W);
  localparam logic [RD_W-1:0] ADC_MASK =
    (ADC_BITS >= RD_W) ? {RD_W{1'b1}} : RD_W'((1 << ADC_BITS) - 1);
  localparam logic [CNT_W-1:0] CNT_TARGET = CNT_W'(SAMPLE_COUNT);
  localparam logic [DV_W-1:0]  AVG_DIVISOR = DV_W'(SAMPLE_COUNT);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(DIVD_W - 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]        state_q;
  logic              calib_q;
  logic [SUM_W-1:0]  sum_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [RD_W-1:0]   cal_q;
  logic [FS_W-1:0]   fs_q;
  logic              avg_op_q;     // divider runs an average, not a conversion
  logic [ITER_W-1:0] iter_q;

  // divider datapath
  logic [DV_W-1:0]   rem_q;
  logic [DIVD_W-1:0] quo_q;
  logic [DV_W-1:0]   dvs_q;
  logic [RD_W-1:0]   rd_q;

  // pending result
  logic [MV_W-1:0]   res_mv_q;
  logic              res_sat_q;
  logic              res_derr_q;
  logic              res_prog_q;
  logic              res_strb_q;
  logic [RD_W-1:0]   res_cal_q;

  // output register
  logic              out_vld_q;
  logic [31:0]       out_dat_q;

  logic              in_beat;
  logic              out_free;
  logic [RD_W-1:0]   rd_masked;
  logic [SUM_W-1:0]  sum_d;
  logic [CNT_W-1:0]  cnt_d;
  logic [DV_W:0]     shifted;
  logic [DV_W:0]     diff;
  logic              take;
  logic [DV_W-1:0]   rem_d;
  logic [DIVD_W-1:0] prod;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_dat_q;

  assign rd_masked = s_axis_tdata[RD_W-1:0] & ADC_MASK;
  assign sum_d     = sum_q + SUM_W'(rd_masked);
  assign cnt_d     = cnt_q + CNT_W'(1);

  // one restoring division step: shift in the next dividend bit, trial subtract
  assign shifted = {rem_q, quo_q[DIVD_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign take    = !diff[DV_W];
  assign rem_d   = take ? diff[DV_W-1:0] : shifted[DV_W-1:0];

  // product for conversion, registered into the dividend in S_MUL
  assign prod = DIVD_W'(fs_q) * DIVD_W'(rd_q);

  // control state, calibration state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      calib_q   <= 1'b0;
      sum_q     <= '0;
      cnt_q     <= '0;
      cal_q     <= '0;
      fs_q      <= FS_RESET;
      avg_op_q  <= 1'b0;
      iter_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_SAVED_CAL:  cal_q <= cfg_data_i[RD_W-1:0] & ADC_MASK;
          REG_FULL_SCALE: fs_q  <= cfg_data_i[FS_W-1:0];
          default: ;
        endcase
      end

      if (out_vld_q && m_axis_tready) begin
        out_vld_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_beat) begin
            state_q <= S_DONE;
            case (s_axis_tuser)
              ACT_START: begin
                calib_q <= 1'b1;
                sum_q   <= '0;
                cnt_q   <= '0;
              end
              ACT_SAMPLE: begin
                if (calib_q) begin
                  sum_q <= sum_d;
                  cnt_q <= cnt_d;
                  if (cnt_d >= CNT_TARGET) begin
                    calib_q  <= 1'b0;
                    avg_op_q <= 1'b1;
                    iter_q   <= ITER_LAST;
                    state_q  <= S_DIV;
                  end
                end
              end
              ACT_CONVERT: begin
                if (cal_q != '0) begin
                  avg_op_q <= 1'b0;
                  state_q  <= S_MUL;
                end
              end
              default: ;
            endcase
          end
        end
        S_MUL: begin
          iter_q  <= ITER_LAST;
          state_q <= S_DIV;
        end
        S_DIV: begin
          iter_q <= iter_q - ITER_W'(1);
          if (iter_q == '0) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (avg_op_q) begin
            cal_q <= quo_q[RD_W-1:0] & ADC_MASK;
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_vld_q <= 1'b1;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // divider and result payload
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          rd_q       <= rd_masked;
          dvs_q      <= cal_q;
          rem_q      <= '0;
          res_mv_q   <= '0;
          res_sat_q  <= 1'b0;
          res_derr_q <= 1'b0;
          res_strb_q <= 1'b0;
          res_cal_q  <= cal_q;
          res_prog_q <= calib_q;
          case (s_axis_tuser)
            ACT_START: res_prog_q <= 1'b1;
            ACT_SAMPLE: begin
              if (calib_q && (cnt_d >= CNT_TARGET)) begin
                res_prog_q <= 1'b0;
                res_strb_q <= 1'b1;
                dvs_q      <= AVG_DIVISOR;
                quo_q      <= DIVD_W'(sum_d);
              end
            end
            ACT_CONVERT: begin
              if (cal_q == '0) begin
                res_mv_q   <= MV_MAX;
                res_derr_q <= 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_MUL: quo_q <= prod;
      S_DIV: begin
        rem_q <= rem_d;
        quo_q <= {quo_q[DIVD_W-2:0], take};
      end
      S_FIN: begin
        if (avg_op_q) begin
          res_cal_q <= quo_q[RD_W-1:0] & ADC_MASK;
        end else if (|quo_q[DIVD_W-1:MV_W]) begin
          res_mv_q  <= MV_MAX;
          res_sat_q <= 1'b1;
        end else begin
          res_mv_q <= quo_q[MV_W-1:0];
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_dat_q <= {2'b00, res_cal_q, res_strb_q, res_prog_q, res_derr_q,
                        res_sat_q, res_mv_q};
        end
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  // a zero calibration value never reports saturation as well
  a_derr_not_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[17] && m_axis_tdata[16]))
    else $error("divide_error and saturated both set");

  // a divide error always carries full-scale millivolts
  a_derr_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[17]) |-> (m_axis_tdata[15:0] == MV_MAX))
    else $error("divide_error without full-scale result");

  // a store strobe ends the calibration
  a_strobe_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[19]) |-> !m_axis_tdata[18])
    else $error("store_strobe while calibration still running");

  // the divider leaves its loop after the last quotient bit
  a_div_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && iter_q == '0) |=> (state_q == S_FIN))
    else $error("divider did not finish on its last step");
`endif

endmodule : adc_averaging_calibrator

`default_nettype wire
